// ===== design/bhq_pkg.sv =====
// shared types, constants and the symbol lookup for the hqx stream decoder
`default_nettype none

package bhq_pkg;

  localparam logic [7:0] RLE_MARK = 8'h90;
  localparam logic [7:0] END_CHAR = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_END      = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_TRUNCRUN = 3'd3,
    ST_NOPREV   = 3'd4
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] digit;
  } sym_t;

  // alphabet runs as contiguous character ranges, each mapped to a digit range
  function automatic sym_t sym_lookup(input logic [7:0] ch);
    sym_t r;
    r.ok    = 1'b1;
    r.digit = '0;
    priority if (ch >= 8'h21 && ch <= 8'h2D) begin
      r.digit = 6'(ch - 8'h21);
    end else if (ch >= 8'h30 && ch <= 8'h36) begin
      r.digit = 6'(ch - 8'h30 + 8'd13);
    end else if (ch == 8'h38 || ch == 8'h39) begin
      r.digit = 6'(ch - 8'h38 + 8'd20);
    end else if (ch >= 8'h40 && ch <= 8'h4E) begin
      r.digit = 6'(ch - 8'h40 + 8'd22);
    end else if (ch >= 8'h50 && ch <= 8'h56) begin
      r.digit = 6'(ch - 8'h50 + 8'd37);
    end else if (ch >= 8'h58 && ch <= 8'h5B) begin
      r.digit = 6'(ch - 8'h58 + 8'd44);
    end else if (ch >= 8'h60 && ch <= 8'h66) begin
      r.digit = 6'(ch - 8'h60 + 8'd48);
    end else if (ch >= 8'h68 && ch <= 8'h6D) begin
      r.digit = 6'(ch - 8'h68 + 8'd55);
    end else if (ch >= 8'h70 && ch <= 8'h72) begin
      r.digit = 6'(ch - 8'h70 + 8'd61);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/bhq_if.sv =====
// valid/ready channel interfaces for encoded characters and decoded results
`default_nettype none

interface bhq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface bhq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [7:0] repeat_count;
  logic [2:0] status;

  modport source (output valid, output out_byte, output repeat_count, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input repeat_count, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== design/binhex_hqx_stream_decoder.sv =====
// top level: hqx text to bytes with rle90 run expansion
// Takes one encoded character per transfer and returns at most one result per
// character: a byte with its repeat count, or a status for the closing colon
// or an error, after which the decoder is back in its reset state. Characters
// pass through an input register and the decode logic into a result register,
// so one character is taken every cycle while the output side keeps up.
// Whitespace and characters that only fill bits never wait on the output
// side.
`default_nettype none

module binhex_hqx_stream_decoder (
  input  wire          clk,
  input  wire          rst_n,
  bhq_in_if.sink       in_ch,
  bhq_out_if.source    out_ch
);

  // input register
  logic       in_v_r;
  logic [7:0] in_char_r;

  // decoder state
  logic [5:0] left_bits_r, left_bits_nxt;
  logic [2:0] left_cnt_r, left_cnt_nxt;
  logic [7:0] prev_byte_r, prev_byte_nxt;
  logic       have_prev_r, have_prev_nxt;
  logic       run_pend_r, run_pend_nxt;

  // result register
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic [7:0] out_cnt_r;
  logic [2:0] out_st_r;

  logic          res_v;
  logic [7:0]    res_byte;
  logic [7:0]    res_cnt;
  bhq_pkg::status_t res_st;

  bhq_pkg::sym_t sym;
  logic [11:0]   acc;
  logic [3:0]    cnt_sum;
  logic [2:0]    sh;
  logic [7:0]    pbyte;
  logic          adv;

  always_comb begin
    sym     = bhq_pkg::sym_lookup(in_char_r);
    acc     = {left_bits_r, sym.digit};
    cnt_sum = {1'b0, left_cnt_r} + 4'd6;
    sh      = 3'(cnt_sum - 4'd8);
    pbyte   = 8'(acc >> sh);

    res_v         = 1'b0;
    res_byte      = '0;
    res_cnt       = '0;
    res_st        = bhq_pkg::ST_DATA;
    left_bits_nxt = left_bits_r;
    left_cnt_nxt  = left_cnt_r;
    prev_byte_nxt = prev_byte_r;
    have_prev_nxt = have_prev_r;
    run_pend_nxt  = run_pend_r;

    priority if (in_char_r == bhq_pkg::END_CHAR) begin
      res_v  = 1'b1;
      res_st = run_pend_r ? bhq_pkg::ST_TRUNCRUN : bhq_pkg::ST_END;
      left_bits_nxt = '0;
      left_cnt_nxt  = '0;
      prev_byte_nxt = '0;
      have_prev_nxt = 1'b0;
      run_pend_nxt  = 1'b0;
    end else if (in_char_r == bhq_pkg::CH_SPACE || in_char_r == bhq_pkg::CH_TAB ||
                 in_char_r == bhq_pkg::CH_CR || in_char_r == bhq_pkg::CH_LF) begin
      res_v = 1'b0;
    end else if (!sym.ok) begin
      res_v  = 1'b1;
      res_st = bhq_pkg::ST_BADCHAR;
      left_bits_nxt = '0;
      left_cnt_nxt  = '0;
      prev_byte_nxt = '0;
      have_prev_nxt = 1'b0;
      run_pend_nxt  = 1'b0;
    end else if (cnt_sum < 4'd8) begin
      left_bits_nxt = sym.digit;
      left_cnt_nxt  = 3'(cnt_sum);
    end else begin
      left_bits_nxt = 6'(acc & ((12'd1 << sh) - 12'd1));
      left_cnt_nxt  = sh;
      if (run_pend_r) begin
        run_pend_nxt = 1'b0;
        priority if (pbyte == 8'd0) begin
          // escaped marker
          res_v         = 1'b1;
          res_byte      = bhq_pkg::RLE_MARK;
          res_cnt       = 8'd1;
          prev_byte_nxt = bhq_pkg::RLE_MARK;
          have_prev_nxt = 1'b1;
        end else if (!have_prev_r) begin
          res_v  = 1'b1;
          res_st = bhq_pkg::ST_NOPREV;
          left_bits_nxt = '0;
          left_cnt_nxt  = '0;
          prev_byte_nxt = '0;
          have_prev_nxt = 1'b0;
        end else if (pbyte != 8'd1) begin
          res_v    = 1'b1;
          res_byte = prev_byte_r;
          res_cnt  = pbyte - 8'd1;
        end else begin
          res_v = 1'b0;
        end
      end else if (pbyte == bhq_pkg::RLE_MARK) begin
        run_pend_nxt = 1'b1;
      end else begin
        res_v         = 1'b1;
        res_byte      = pbyte;
        res_cnt       = 8'd1;
        prev_byte_nxt = pbyte;
        have_prev_nxt = 1'b1;
      end
    end
  end

  // the held character moves on unless it has a result and the result slot is blocked
  assign adv         = in_v_r && (!res_v || !out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      left_bits_r <= '0;
      left_cnt_r  <= '0;
      prev_byte_r <= '0;
      have_prev_r <= 1'b0;
      run_pend_r  <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        left_bits_r <= left_bits_nxt;
        left_cnt_r  <= left_cnt_nxt;
        prev_byte_r <= prev_byte_nxt;
        have_prev_r <= have_prev_nxt;
        run_pend_r  <= run_pend_nxt;
      end
      if (adv && res_v) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.text_char;
    end
    if (adv && res_v) begin
      out_byte_r <= res_byte;
      out_cnt_r  <= res_cnt;
      out_st_r   <= res_st;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.repeat_count = out_cnt_r;
  assign out_ch.status       = out_st_r;

endmodule

`default_nettype wire

// ===== test/hqx_decode_checker.sv =====
// checker for the hqx stream decoder: predicts results from input transfers and compares them
`timescale 1ns / 1ps

module hqx_decode_checker (
  input  wire clk,
  input  wire rst_n,
  bhq_in_if   in_ch,
  bhq_out_if  out_ch,
  output int  fail_count,
  output int  outstanding
);

  // 64-symbol alphabet, index is the 6-bit digit (\140 is the backtick)
  localparam string HQX_ALPHABET =
    "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[\140abcdefhijklmpqr";

  typedef struct packed {
    logic [7:0]       value;
    logic [7:0]       copies;
    bhq_pkg::status_t status;
  } decoded_t;

  decoded_t   decoded_q[$];
  int         mismatches = 0;
  int         queued = 0;

  // decoder state as the block should hold it
  logic [5:0] spare_bits;
  int         spare_cnt;
  logic [7:0] last_byte;
  bit         last_valid;
  bit         mark_seen;

  assign fail_count  = mismatches;
  assign outstanding = queued;

  function automatic int hqx_digit(input logic [7:0] ch);
    int d;
    d = -1;
    for (int k = 0; k < 64; k++) begin
      if (HQX_ALPHABET[k] == ch) d = k;
    end
    return d;
  endfunction

  task automatic report_fail(input string msg);
    $display("ERROR t=%0t %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_decoder();
    spare_bits = '0;
    spare_cnt  = 0;
    last_byte  = '0;
    last_valid = 1'b0;
    mark_seen  = 1'b0;
  endtask

  task automatic queue_decoded(input logic [7:0] value, input logic [7:0] copies,
                               input bhq_pkg::status_t st);
    decoded_t r;
    r.value  = value;
    r.copies = copies;
    r.status = st;
    decoded_q.push_back(r);
  endtask

  task automatic decode_char(input logic [7:0] ch);
    int         digit;
    int         nbits;
    logic [11:0] acc;
    logic [7:0] val;
    digit = hqx_digit(ch);
    if (ch == bhq_pkg::END_CHAR) begin
      queue_decoded(8'h00, 8'h00, mark_seen ? bhq_pkg::ST_TRUNCRUN : bhq_pkg::ST_END);
      clear_decoder();
    end else if (ch == bhq_pkg::CH_SPACE || ch == bhq_pkg::CH_TAB ||
                 ch == bhq_pkg::CH_CR || ch == bhq_pkg::CH_LF) begin
      // skipped, no state change
    end else if (digit < 0) begin
      queue_decoded(8'h00, 8'h00, bhq_pkg::ST_BADCHAR);
      clear_decoder();
    end else begin
      acc   = {spare_bits, 6'(digit)};
      nbits = spare_cnt + 6;
      if (nbits < 8) begin
        spare_bits = acc[5:0];
        spare_cnt  = nbits;
      end else begin
        nbits      = nbits - 8;
        val        = 8'(acc >> nbits);
        spare_bits = 6'(acc & ((12'd1 << nbits) - 12'd1));
        spare_cnt  = nbits;
        if (mark_seen) begin
          mark_seen = 1'b0;
          if (val == 8'h00) begin
            // escaped marker is a literal
            last_byte  = bhq_pkg::RLE_MARK;
            last_valid = 1'b1;
            queue_decoded(bhq_pkg::RLE_MARK, 8'd1, bhq_pkg::ST_DATA);
          end else if (!last_valid) begin
            queue_decoded(8'h00, 8'h00, bhq_pkg::ST_NOPREV);
            clear_decoder();
          end else if (val != 8'd1) begin
            queue_decoded(last_byte, val - 8'd1, bhq_pkg::ST_DATA);
          end
        end else if (val == bhq_pkg::RLE_MARK) begin
          mark_seen = 1'b1;
        end else begin
          last_byte  = val;
          last_valid = 1'b1;
          queue_decoded(val, 8'd1, bhq_pkg::ST_DATA);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      clear_decoder();
      decoded_q.delete();
    end else begin
      // results pass through the input and result registers, so the result side never needs this edge's input
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report_fail($sformatf("unexpected result byte %0h count %0d status %0d",
                                out_ch.out_byte, out_ch.repeat_count, out_ch.status));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.value)
            report_fail($sformatf("out_byte got %0h expected %0h",
                                  out_ch.out_byte, want.value));
          if (out_ch.repeat_count !== want.copies)
            report_fail($sformatf("repeat_count got %0d expected %0d",
                                  out_ch.repeat_count, want.copies));
          if (out_ch.status !== want.status)
            report_fail($sformatf("status got %0d expected %0d",
                                  out_ch.status, want.status));
        end
      end
      if (in_ch.valid && in_ch.ready) decode_char(in_ch.text_char);
    end
    queued = decoded_q.size();
  end

endmodule

// ===== test/binhex_hqx_stream_decoder_tb.sv =====
// testbench top for the hqx stream decoder: reset, clock, stimulus and verdict
`timescale 1ns / 1ps

module binhex_hqx_stream_decoder_tb;

  localparam int RUN_LIMIT       = 500000;
  localparam int RANDOM_CHARS    = 900;
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n;

  bhq_in_if  in_ch_if ();
  bhq_out_if out_ch_if ();

  int            fail_count;
  int            outstanding;
  int            cycle_count = 0;
  int            chars_sent = 0;
  bit            no_idle = 1'b0;
  bit            hold_off_req = 1'b0;
  bit            hold_done = 1'b0;
  logic [7:0]    digit_char [64];
  logic [11:0]   enc_acc;
  int            enc_bits;
  bhq_pkg::sym_t sym_c;

  binhex_hqx_stream_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch_if),
    .out_ch (out_ch_if)
  );

  hqx_decode_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch_if),
    .out_ch      (out_ch_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL binhex_hqx_stream_decoder");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic bit is_space(input logic [7:0] ch);
    return ch == bhq_pkg::CH_SPACE || ch == bhq_pkg::CH_TAB ||
           ch == bhq_pkg::CH_CR || ch == bhq_pkg::CH_LF;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return bhq_pkg::CH_SPACE;
      1:       return bhq_pkg::CH_TAB;
      2:       return bhq_pkg::CH_CR;
      default: return bhq_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0]    c;
    bhq_pkg::sym_t s;
    do begin
      c = 8'($urandom);
      s = bhq_pkg::sym_lookup(c);
    end while (s.ok || c == bhq_pkg::END_CHAR || is_space(c));
    return c;
  endfunction

  function automatic logic [7:0] run_count();
    case ($urandom_range(0, 7))
      0:       return 8'd1;
      1:       return 8'd2;
      2:       return 8'd255;
      default: return 8'($urandom_range(3, 254));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_ch_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end
  end

  task automatic send_char(input logic [7:0] ch);
    in_ch_if.valid     <= 1'b1;
    in_ch_if.text_char <= ch;
    @(posedge clk);
    while (!in_ch_if.ready) @(posedge clk);
    if (!is_space(ch)) chars_sent++;
    // keep offering during the hold-off so the block backs up
    if (!no_idle && !hold_off_req && $urandom_range(0, 3) == 0) begin
      in_ch_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic put_digit(input logic [5:0] d);
    if ($urandom_range(0, 15) == 0) send_char(pick_space());
    send_char(digit_char[d]);
  endtask

  task automatic start_section();
    enc_acc  = '0;
    enc_bits = 0;
  endtask

  // pack bytes msb first into 6-bit digits
  task automatic put_byte(input logic [7:0] b);
    enc_acc  = {enc_acc[3:0], b};
    enc_bits = enc_bits + 8;
    while (enc_bits >= 6) begin
      enc_bits = enc_bits - 6;
      put_digit(6'(enc_acc >> enc_bits));
      enc_acc = enc_acc & ((12'd1 << enc_bits) - 12'd1);
    end
  endtask

  task automatic flush_bits();
    if (enc_bits > 0) put_digit(6'(enc_acc << (6 - enc_bits)));
    start_section();
  endtask

  task automatic random_section();
    int  nbytes;
    int  kind;
    bit  have_prev;
    start_section();
    no_idle   = ($urandom_range(0, 4) == 0);
    have_prev = 1'b0;
    if ($urandom_range(0, 7) == 0) begin
      // raw noise over the whole character range
      repeat ($urandom_range(3, 15)) send_char(8'($urandom));
      send_char(bhq_pkg::END_CHAR);
    end else begin
      nbytes = $urandom_range(1, 12);
      for (int i = 0; i < nbytes; i++) begin
        kind = $urandom_range(0, 9);
        // runs at the very start only now and then
        if (!have_prev && kind >= 1 && kind <= 3 && $urandom_range(0, 7) != 0) kind = 9;
        case (kind)
          0: begin
            put_byte(bhq_pkg::RLE_MARK);
            put_byte(8'h00);
            have_prev = 1'b1;
          end
          1, 2: begin
            put_byte(bhq_pkg::RLE_MARK);
            put_byte(run_count());
          end
          3: begin
            put_byte(bhq_pkg::RLE_MARK);
            put_byte(bhq_pkg::RLE_MARK);
          end
          default: begin
            put_byte(8'($urandom));
            have_prev = 1'b1;
          end
        endcase
      end
      case ($urandom_range(0, 9))
        0: begin
          put_byte(bhq_pkg::RLE_MARK);
          flush_bits();
          send_char(bhq_pkg::END_CHAR);
        end
        1: send_char(bad_char());
        2: send_char(bhq_pkg::END_CHAR);
        default: begin
          flush_bits();
          send_char(bhq_pkg::END_CHAR);
        end
      endcase
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch_if.valid     <= 1'b0;
    in_ch_if.text_char <= 8'h00;
    for (int c = 255; c >= 0; c--) begin
      sym_c = bhq_pkg::sym_lookup(8'(c));
      if (sym_c.ok) digit_char[sym_c.digit] = 8'(c);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, all whitespace, marker cases and every status
    no_idle = 1'b1;
    start_section();
    send_char(bhq_pkg::CH_SPACE);
    send_char(bhq_pkg::CH_TAB);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(bhq_pkg::RLE_MARK);
    put_byte(8'h00);
    put_byte(bhq_pkg::RLE_MARK);
    put_byte(8'hFF);
    put_byte(bhq_pkg::RLE_MARK);
    put_byte(8'h01);
    send_char(bhq_pkg::CH_CR);
    send_char(bhq_pkg::CH_LF);
    put_byte(bhq_pkg::RLE_MARK);
    put_byte(bhq_pkg::RLE_MARK);
    flush_bits();
    send_char(bhq_pkg::END_CHAR);
    no_idle = 1'b0;
    put_byte(bhq_pkg::RLE_MARK);
    put_byte(8'h05);
    flush_bits();
    send_char(8'h00);
    send_char(8'hFF);
    put_byte(bhq_pkg::RLE_MARK);
    flush_bits();
    send_char(bhq_pkg::END_CHAR);

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      // one long hold-off once a third of the characters are through
      if (chars_sent >= 300 && !hold_done) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      random_section();
    end
    in_ch_if.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS binhex_hqx_stream_decoder");
    end else begin
      $display("FAIL binhex_hqx_stream_decoder");
    end
    $finish;
  end

endmodule
